FILE: design/gaussian_smoothing_edge_difference_core_defines.svh
// ----------------------------------------------------------------------------
// Gaussian smoothing core assertion macros
// Shared concurrent assertion forms clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_SMOOTHING_EDGE_DIFFERENCE_CORE_DEFINES_SVH
`define GAUSSIAN_SMOOTHING_EDGE_DIFFERENCE_CORE_DEFINES_SVH

// same-cycle implication
`define GSED_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GSED_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gsed_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian smoothing core package
// Shared types, register map, reset values and the kernel tap classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package gsed_pkg;

    localparam int DEF_KSIZE      = 5;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int DIM_W   = 11;
    localparam int WT_W    = 8;
    localparam int N_WT    = 6;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd256;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd256;
    localparam logic [WT_W-1:0]  RST_WT0    = 8'd8;
    localparam logic [WT_W-1:0]  RST_WT1    = 8'd6;
    localparam logic [WT_W-1:0]  RST_WT2    = 8'd5;
    localparam logic [WT_W-1:0]  RST_WT4    = 8'd3;
    localparam logic [WT_W-1:0]  RST_WT5    = 8'd3;
    localparam logic [WT_W-1:0]  RST_WT8    = 8'd1;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_WT0    = 3'd2,
        REG_WT1    = 3'd3,
        REG_WT2    = 3'd4,
        REG_WT4    = 3'd5,
        REG_WT5    = 3'd6,
        REG_WT8    = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        CLS_D0   = 3'd0,
        CLS_D1   = 3'd1,
        CLS_D2   = 3'd2,
        CLS_D4   = 3'd3,
        CLS_D5   = 3'd4,
        CLS_D8   = 3'd5,
        CLS_NONE = 3'd6
    } wt_class_t;

    typedef struct packed {
        logic [DIM_W-1:0]           img_width;
        logic [DIM_W-1:0]           img_height;
        logic [N_WT-1:0][WT_W-1:0]  wt;
    } cfg_t;

    typedef struct packed {
        logic latch;
        logic eval;
        logic mul_k;
        logic mul_n;
        logic rd_orig;
        logic cap_orig;
        logic tap_rd;
        logic tap_acc;
        logic div_init;
        logic div_step;
        logic finish;
        logic clear_cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic complete;
        logic flush;
        logic emit_ok;
        logic out_done;
        logic interior;
        logic tap_last;
        logic div_last;
    } dp_stat_t;

    function automatic wt_class_t tap_class(input int dy, input int dx, input int half);
        int oy;
        int ox;
        int d2;
        wt_class_t cls;
        oy = dy - half;
        ox = dx - half;
        d2 = oy * oy + ox * ox;
        unique case (d2)
            0:       cls = CLS_D0;
            1:       cls = CLS_D1;
            2:       cls = CLS_D2;
            4:       cls = CLS_D4;
            5:       cls = CLS_D5;
            8:       cls = CLS_D8;
            default: cls = CLS_NONE;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

FILE: design/gsed_regs.sv
// ----------------------------------------------------------------------------
// Gaussian smoothing configuration registers
// APB-style register file holding image size and kernel weights.
// ----------------------------------------------------------------------------
`default_nettype none

module gsed_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gsed_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [gsed_pkg::PDATA_W-1:0]  pwdata,
    output logic      [gsed_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output gsed_pkg::cfg_t                     cfg_o
);

    gsed_pkg::reg_idx_t idx;
    gsed_pkg::cfg_t     cfg_reg;
    logic               wr_en;

    assign idx    = gsed_pkg::reg_idx_t'(paddr[gsed_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg_o  = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.img_width  <= gsed_pkg::RST_WIDTH;
            cfg_reg.img_height <= gsed_pkg::RST_HEIGHT;
            cfg_reg.wt[0]      <= gsed_pkg::RST_WT0;
            cfg_reg.wt[1]      <= gsed_pkg::RST_WT1;
            cfg_reg.wt[2]      <= gsed_pkg::RST_WT2;
            cfg_reg.wt[3]      <= gsed_pkg::RST_WT4;
            cfg_reg.wt[4]      <= gsed_pkg::RST_WT5;
            cfg_reg.wt[5]      <= gsed_pkg::RST_WT8;
        end
        else if (wr_en)
        begin
            unique case (idx)
                gsed_pkg::REG_WIDTH:  cfg_reg.img_width  <= pwdata[gsed_pkg::DIM_W-1:0];
                gsed_pkg::REG_HEIGHT: cfg_reg.img_height <= pwdata[gsed_pkg::DIM_W-1:0];
                gsed_pkg::REG_WT0:    cfg_reg.wt[0]      <= pwdata[gsed_pkg::WT_W-1:0];
                gsed_pkg::REG_WT1:    cfg_reg.wt[1]      <= pwdata[gsed_pkg::WT_W-1:0];
                gsed_pkg::REG_WT2:    cfg_reg.wt[2]      <= pwdata[gsed_pkg::WT_W-1:0];
                gsed_pkg::REG_WT4:    cfg_reg.wt[3]      <= pwdata[gsed_pkg::WT_W-1:0];
                gsed_pkg::REG_WT5:    cfg_reg.wt[4]      <= pwdata[gsed_pkg::WT_W-1:0];
                gsed_pkg::REG_WT8:    cfg_reg.wt[5]      <= pwdata[gsed_pkg::WT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            gsed_pkg::REG_WIDTH:  prdata = gsed_pkg::PDATA_W'(cfg_reg.img_width);
            gsed_pkg::REG_HEIGHT: prdata = gsed_pkg::PDATA_W'(cfg_reg.img_height);
            gsed_pkg::REG_WT0:    prdata = gsed_pkg::PDATA_W'(cfg_reg.wt[0]);
            gsed_pkg::REG_WT1:    prdata = gsed_pkg::PDATA_W'(cfg_reg.wt[1]);
            gsed_pkg::REG_WT2:    prdata = gsed_pkg::PDATA_W'(cfg_reg.wt[2]);
            gsed_pkg::REG_WT4:    prdata = gsed_pkg::PDATA_W'(cfg_reg.wt[3]);
            gsed_pkg::REG_WT5:    prdata = gsed_pkg::PDATA_W'(cfg_reg.wt[4]);
            gsed_pkg::REG_WT8:    prdata = gsed_pkg::PDATA_W'(cfg_reg.wt[5]);
        endcase
    end

endmodule

`default_nettype wire

FILE: design/gsed_ctrl.sv
// ----------------------------------------------------------------------------
// Gaussian smoothing controller
// Sequences one request at a time through the datapath and owns out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_smoothing_edge_difference_core_defines.svh"

module gsed_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  gsed_pkg::dp_stat_t      stat_i,
    output gsed_pkg::dp_cmd_t       cmd_o
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULK,
        ST_MULN,
        ST_CMP,
        ST_ORIG,
        ST_ORIGW,
        ST_TRD,
        ST_TACC,
        ST_DINIT,
        ST_DSTEP,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd_o      = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_o.latch = in_valid;
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd_o.eval = 1'b1;
                if (!stat_i.complete && stat_i.flush)
                    state_next = ST_IDLE;
                else
                    state_next = ST_MULK;
            end
            ST_MULK:
            begin
                cmd_o.mul_k = 1'b1;
                state_next  = ST_MULN;
            end
            ST_MULN:
            begin
                cmd_o.mul_n = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                cmd_o.clear_cnt = stat_i.emit_ok && stat_i.out_done;
                if (stat_i.emit_ok && !stat_i.out_done)
                    state_next = ST_ORIG;
                else
                    state_next = ST_IDLE;
            end
            ST_ORIG:
            begin
                cmd_o.rd_orig = 1'b1;
                state_next    = ST_ORIGW;
            end
            ST_ORIGW:
            begin
                cmd_o.cap_orig = 1'b1;
                state_next     = stat_i.interior ? ST_TRD : ST_FIN;
            end
            ST_TRD:
            begin
                cmd_o.tap_rd = 1'b1;
                state_next   = ST_TACC;
            end
            ST_TACC:
            begin
                cmd_o.tap_acc = 1'b1;
                state_next    = stat_i.tap_last ? ST_DINIT : ST_TRD;
            end
            ST_DINIT:
            begin
                cmd_o.div_init = 1'b1;
                state_next     = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                cmd_o.div_step = 1'b1;
                if (stat_i.div_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd_o.finish = out_free;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_o.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    `GSED_ASSERT_IMP(a_fin_free, cmd_o.finish, !out_valid_reg || out_ready, "result overwritten")
    `GSED_ASSERT_NXT(a_acc_eval, in_valid && in_ready, state_reg == ST_EVAL, "request not evaluated")
    `GSED_ASSERT_IMP(a_out_rise, $rose(out_valid_reg), $past(state_reg) == ST_FIN, "stray result")
    `GSED_ASSERT_NXT(a_tap_div, cmd_o.tap_acc && stat_i.tap_last, state_reg == ST_DINIT,
        "divide skipped")

endmodule

`default_nettype wire

FILE: design/gsed_dp.sv
// ----------------------------------------------------------------------------
// Gaussian smoothing datapath
// Line store, raster counters, weighted accumulator and ceiling divider.
// ----------------------------------------------------------------------------
`default_nettype none

module gsed_dp #(
    parameter int KSIZE      = gsed_pkg::DEF_KSIZE,
    parameter int MAX_WIDTH  = gsed_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gsed_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  gsed_pkg::cfg_t      cfg_i,
    input  gsed_pkg::dp_cmd_t   cmd_i,
    output gsed_pkg::dp_stat_t  stat_o,
    input  wire logic           in_cmd,
    input  wire logic [7:0]     in_pixel,
    output logic      [7:0]     smoothed,
    output logic      [7:0]     edge_res,
    output logic                last_of_frame
);

    localparam int HALF  = KSIZE / 2;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int CIW   = $clog2(MAX_WIDTH);
    localparam int KW    = $clog2(KSIZE);
    localparam int DEPTH = KSIZE * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = CW + RW;
    localparam int CMPW  = PW + 2;
    localparam int ACCW  = $clog2(KSIZE * KSIZE * 255 * 255 + 1);
    localparam int TOTW  = $clog2(KSIZE * KSIZE * 255 + 1);
    localparam int DW    = (ACCW + 1 > TOTW + 8) ? ACCW + 1 : TOTW + 8;

    logic [7:0] mem [DEPTH];

    logic [RW-1:0]   in_row_reg, out_row_reg;
    logic [CW-1:0]   in_col_reg, out_col_reg;
    logic [KW-1:0]   in_mod_reg, out_mod_reg;

    logic            flush_reg, wc_reg;
    logic [7:0]      pix_reg, rdata_reg, orig_reg, q_reg;
    logic [PW-1:0]   prodk_reg, prodn_reg;
    logic [ACCW-1:0] acc_reg;
    logic [TOTW-1:0] tot_reg;
    logic [KW-1:0]   dy_reg, dx_reg, trow_reg;
    logic [DW-1:0]   rem_reg;
    logic [2:0]      bit_reg;
    logic [7:0]      sm_reg, edge_reg;
    logic            last_reg;

    logic [31:0]     w_raw, h_raw;
    logic [CW-1:0]   w;
    logic [RW-1:0]   h;
    logic            complete, in_wrap, out_wrap, interior, last_px;
    logic [CW-1:0]   in_col_inc, out_col_inc, tcol;
    logic [RW-1:0]   in_row_inc, out_row_inc;
    logic [KW-1:0]   in_mod_inc, out_mod_inc, trow_inc, tstart;
    logic [KW:0]     tsum;
    logic [CW+1:0]   lag;
    logic [CMPW-1:0] lhs, rhs;
    logic [AW-1:0]   waddr, oaddr, taddr, raddr;
    logic            we, re;
    gsed_pkg::wt_class_t cls;
    logic [7:0]      wt;
    logic [15:0]     prod;
    logic [DW-1:0]   trial;
    logic [7:0]      sm;
    logic            tap_last;

    assign w_raw = 32'(cfg_i.img_width);
    assign h_raw = 32'(cfg_i.img_height);
    assign w = (w_raw == 32'd0) ? CW'(1) :
               (w_raw > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w_raw);
    assign h = (h_raw == 32'd0) ? RW'(1) :
               (h_raw > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(h_raw);

    assign complete    = (in_row_reg >= h);
    assign in_col_inc  = in_col_reg + CW'(1);
    assign in_wrap     = (in_col_inc >= w);
    assign in_row_inc  = in_row_reg + RW'(1);
    assign in_mod_inc  = (in_mod_reg == KW'(KSIZE - 1)) ? '0 : in_mod_reg + KW'(1);
    assign out_col_inc = out_col_reg + CW'(1);
    assign out_wrap    = (out_col_inc >= w);
    assign out_row_inc = out_row_reg + RW'(1);
    assign out_mod_inc = (out_mod_reg == KW'(KSIZE - 1)) ? '0 : out_mod_reg + KW'(1);

    assign lag = (CW + 2)'(HALF) * {2'b00, w} + (CW + 2)'(HALF);
    assign lhs = CMPW'(prodk_reg) + CMPW'(out_col_reg) + CMPW'(lag);
    assign rhs = CMPW'(prodn_reg) + CMPW'(in_col_reg);

    assign interior = (out_row_reg >= RW'(HALF)) &&
                      (({1'b0, out_row_reg} + (RW + 1)'(HALF)) < {1'b0, h}) &&
                      (out_col_reg >= CW'(HALF)) &&
                      (({1'b0, out_col_reg} + (CW + 1)'(HALF)) < {1'b0, w});
    assign last_px  = ({1'b0, out_row_reg} + (RW + 1)'(1) >= {1'b0, h}) &&
                      ({1'b0, out_col_reg} + (CW + 1)'(1) >= {1'b0, w});

    assign tsum     = (KW + 1)'(out_mod_reg) + (KW + 1)'(KSIZE - HALF);
    assign tstart   = (tsum >= (KW + 1)'(KSIZE)) ? KW'(tsum - (KW + 1)'(KSIZE)) : KW'(tsum);
    assign trow_inc = (trow_reg == KW'(KSIZE - 1)) ? '0 : trow_reg + KW'(1);
    assign tcol     = out_col_reg - CW'(HALF) + CW'(dx_reg);
    assign tap_last = (dy_reg == KW'(KSIZE - 1)) && (dx_reg == KW'(KSIZE - 1));

    assign waddr = AW'(in_mod_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg[CIW-1:0]);
    assign oaddr = AW'(out_mod_reg) * AW'(MAX_WIDTH) + AW'(out_col_reg[CIW-1:0]);
    assign taddr = AW'(trow_reg) * AW'(MAX_WIDTH) + AW'(tcol[CIW-1:0]);
    assign raddr = cmd_i.rd_orig ? oaddr : taddr;
    assign we    = cmd_i.eval && !complete && !flush_reg;
    assign re    = cmd_i.rd_orig || cmd_i.tap_rd;

    assign cls   = gsed_pkg::tap_class(int'(dy_reg), int'(dx_reg), HALF);
    assign wt    = (cls == gsed_pkg::CLS_NONE) ? 8'd0 : cfg_i.wt[cls];
    assign prod  = wt * rdata_reg;
    assign trial = DW'(tot_reg) << bit_reg;

    assign sm = (interior && (tot_reg != '0)) ? q_reg : orig_reg;

    assign stat_o.complete = complete;
    assign stat_o.flush    = flush_reg;
    assign stat_o.emit_ok  = wc_reg || (lhs < rhs);
    assign stat_o.out_done = (out_row_reg >= h);
    assign stat_o.interior = interior;
    assign stat_o.tap_last = tap_last;
    assign stat_o.div_last = (bit_reg == 3'd0);

    assign smoothed      = sm_reg;
    assign edge_res      = edge_reg;
    assign last_of_frame = last_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= pix_reg;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            in_mod_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            out_mod_reg <= '0;
        end
        else if (cmd_i.clear_cnt || (cmd_i.finish && out_wrap && (out_row_inc >= h)))
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            in_mod_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            out_mod_reg <= '0;
        end
        else
        begin
            if (we)
            begin
                if (in_wrap)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_inc;
                    in_mod_reg <= in_mod_inc;
                end
                else
                    in_col_reg <= in_col_inc;
            end
            if (cmd_i.finish)
            begin
                if (out_wrap)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_inc;
                    out_mod_reg <= out_mod_inc;
                end
                else
                    out_col_reg <= out_col_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.latch)
        begin
            flush_reg <= in_cmd;
            pix_reg   <= in_pixel;
        end
        if (cmd_i.eval)
            wc_reg <= complete;
        if (cmd_i.mul_k)
            prodk_reg <= PW'(out_row_reg) * PW'(w);
        if (cmd_i.mul_n)
            prodn_reg <= PW'(in_row_reg) * PW'(w);
        if (cmd_i.cap_orig)
        begin
            orig_reg <= rdata_reg;
            acc_reg  <= '0;
            tot_reg  <= '0;
            dy_reg   <= '0;
            dx_reg   <= '0;
            trow_reg <= tstart;
        end
        if (cmd_i.tap_acc)
        begin
            acc_reg <= acc_reg + ACCW'(prod);
            tot_reg <= tot_reg + TOTW'(wt);
            if (dx_reg == KW'(KSIZE - 1))
            begin
                dx_reg   <= '0;
                dy_reg   <= dy_reg + KW'(1);
                trow_reg <= trow_inc;
            end
            else
                dx_reg <= dx_reg + KW'(1);
        end
        if (cmd_i.div_init)
        begin
            rem_reg <= DW'(acc_reg) + DW'(tot_reg) - DW'(1);
            q_reg   <= '0;
            bit_reg <= 3'd7;
        end
        if (cmd_i.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg        <= rem_reg - trial;
                q_reg[bit_reg] <= 1'b1;
            end
            bit_reg <= bit_reg - 3'd1;
        end
        if (cmd_i.finish)
        begin
            sm_reg   <= sm;
            edge_reg <= (sm > orig_reg) ? (sm - orig_reg) : 8'd0;
            last_reg <= last_px;
        end
    end

endmodule

`default_nettype wire

FILE: design/gaussian_smoothing_edge_difference_core.sv
// Sequence: a request is latched and evaluated (a flush dropped mid-frame stops there), then
// multiplied and compared; a release reads the original, and if interior also taps and divides.
// Throughput: one request at a time; the line store port and the shared tap multiply
// take one tap read and one accumulate step each, the ceiling divide one bit per cycle.
// Reset: asynchronous active low; clears counters and handshake, loads register
// defaults; the line store holds no reset value.
// ----------------------------------------------------------------------------
// Gaussian smoothing edge difference core
// Raster-order Gaussian blur with edge difference, APB configured.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_smoothing_edge_difference_core #(
    parameter int KSIZE      = gsed_pkg::DEF_KSIZE,
    parameter int MAX_WIDTH  = gsed_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gsed_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gsed_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [gsed_pkg::PDATA_W-1:0]  pwdata,
    output logic      [gsed_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [7:0]                    pixel,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [7:0]                    smoothed,
    output logic      [7:0]                    edge_res,
    output logic                               last_of_frame
);

    gsed_pkg::cfg_t     cfg;
    gsed_pkg::dp_cmd_t  dp_cmd;
    gsed_pkg::dp_stat_t dp_stat;

    gsed_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    gsed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat_i    (dp_stat),
        .cmd_o     (dp_cmd)
    );

    gsed_dp #(
        .KSIZE      (KSIZE),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_i         (cfg),
        .cmd_i         (dp_cmd),
        .stat_o        (dp_stat),
        .in_cmd        (cmd),
        .in_pixel      (pixel),
        .smoothed      (smoothed),
        .edge_res      (edge_res),
        .last_of_frame (last_of_frame)
    );

endmodule

`default_nettype wire

FILE: test/gaussian_smoothing_edge_difference_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian smoothing core testbench
// Drives raster frames of fixed and random sizes, weights and pixels through the core,
// predicts every smoothed pixel and edge value and compares them in order.
// ----------------------------------------------------------------------------

typedef struct {
    bit [7:0] smoothed;
    bit [7:0] edge_res;
    bit       last_of_frame;
} gsed_pixel_t;

class gsed_scoreboard;
    localparam int KS   = 5;
    localparam int HK   = KS / 2;
    localparam int MAXW = 1024;
    localparam int MAXH = 1024;

    bit [10:0]   cfg_regs [8];
    bit [7:0]    lines [KS*MAXW];
    int unsigned in_row, in_col, out_row, out_col;
    gsed_pixel_t pending_pixels [$];
    int          errors;

    function new();
        cfg_regs[gsed_pkg::REG_WIDTH]  = 256;
        cfg_regs[gsed_pkg::REG_HEIGHT] = 256;
        cfg_regs[gsed_pkg::REG_WT0]    = 8;
        cfg_regs[gsed_pkg::REG_WT1]    = 6;
        cfg_regs[gsed_pkg::REG_WT2]    = 5;
        cfg_regs[gsed_pkg::REG_WT4]    = 3;
        cfg_regs[gsed_pkg::REG_WT5]    = 3;
        cfg_regs[gsed_pkg::REG_WT8]    = 1;
        errors = 0;
    endfunction

    function int unsigned span(int unsigned v, int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function int unsigned line_addr(int unsigned r, int unsigned c);
        return (r % KS) * MAXW + (c % MAXW);
    endfunction

    function int unsigned weight_of(int d2);
        case (d2)
            0: return cfg_regs[gsed_pkg::REG_WT0];
            1: return cfg_regs[gsed_pkg::REG_WT1];
            2: return cfg_regs[gsed_pkg::REG_WT2];
            4: return cfg_regs[gsed_pkg::REG_WT4];
            5: return cfg_regs[gsed_pkg::REG_WT5];
            8: return cfg_regs[gsed_pkg::REG_WT8];
            default: return 0;
        endcase
    endfunction

    function bit active();
        return (in_row | in_col | out_row | out_col) != 0;
    endfunction

    function bit complete();
        return in_row >= span(cfg_regs[gsed_pkg::REG_HEIGHT], MAXH);
    endfunction

    function void clear_position();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function void release_pixel(int unsigned w, int unsigned h);
        int unsigned orig, sm, acc, tot, wt;
        gsed_pixel_t px;
        acc = 0;
        tot = 0;
        if (out_row >= h)
        begin
            clear_position();
            return;
        end
        orig = lines[line_addr(out_row, out_col)];
        sm = orig;
        if (out_row >= HK && out_row + HK < h && out_col >= HK && out_col + HK < w)
        begin
            for (int dy = -HK; dy <= HK; dy++)
                for (int dx = -HK; dx <= HK; dx++)
                begin
                    wt = weight_of(dy * dy + dx * dx);
                    acc += wt * lines[line_addr(out_row + dy, out_col + dx)];
                    tot += wt;
                end
            if (tot != 0) sm = (acc + tot - 1) / tot;
            if (sm > 255) sm = 255;
        end
        px.smoothed = sm[7:0];
        px.edge_res = (sm > orig) ? 8'(sm - orig) : 8'd0;
        px.last_of_frame = (out_row + 1 >= h && out_col + 1 >= w);
        pending_pixels.push_back(px);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= h) clear_position();
    endfunction

    function void note_request(bit c, bit [7:0] p);
        int unsigned w, h, lag, n_in, k;
        bit was_complete;
        w = span(cfg_regs[gsed_pkg::REG_WIDTH], MAXW);
        h = span(cfg_regs[gsed_pkg::REG_HEIGHT], MAXH);
        lag = HK * w + HK;
        was_complete = in_row >= h;
        if (!was_complete)
        begin
            if (c) return;
            lines[line_addr(in_row, in_col)] = p;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        end
        n_in = (in_row >= h) ? w * h : in_row * w + in_col;
        k = out_row * w + out_col;
        if (was_complete || k + lag < n_in) release_pixel(w, h);
    endfunction

    function void check_result(bit [7:0] sm, bit [7:0] ed, bit lst);
        gsed_pixel_t px;
        if (pending_pixels.size() == 0)
        begin
            $display("%0t: unexpected result sm=%0d edge=%0d last=%0d", $time, sm, ed, lst);
            errors++;
            return;
        end
        px = pending_pixels.pop_front();
        if (px.smoothed !== sm)
        begin
            $display("%0t: smoothed expected %0d actual %0d", $time, px.smoothed, sm);
            errors++;
        end
        if (px.edge_res !== ed)
        begin
            $display("%0t: edge_res expected %0d actual %0d", $time, px.edge_res, ed);
            errors++;
        end
        if (px.last_of_frame !== lst)
        begin
            $display("%0t: last_of_frame expected %0d actual %0d", $time,
                     px.last_of_frame, lst);
            errors++;
        end
    endfunction
endclass

module gaussian_smoothing_edge_difference_core_tb;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 100;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [gsed_pkg::PADDR_W-1:0]  paddr = '0;
    logic [gsed_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [gsed_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          cmd = 1'b0;
    logic [7:0]                    pixel = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [7:0]                    smoothed;
    logic [7:0]                    edge_res;
    logic                          last_of_frame;

    gsed_scoreboard sb = new();
    int  stall_cycles = 0;
    int  ready_hold = 0;
    int  sent = 0;
    bit  steady = 1'b0;

    gaussian_smoothing_edge_difference_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .smoothed(smoothed), .edge_res(edge_res), .last_of_frame(last_of_frame)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(smoothed, edge_res, last_of_frame);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("gaussian_smoothing_edge_difference_core_tb: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if ($urandom_range(0, 2) != 0)
        begin
            out_ready <= 1'b1;
            ready_hold <= $urandom_range(0, 30);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                       : $urandom_range(0, 3);
        end
    end

    task automatic apb_write(gsed_pkg::reg_idx_t idx, int unsigned val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= gsed_pkg::PADDR_W'(idx * 4);
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready) break;
        end
        sb.cfg_regs[idx] = (idx < gsed_pkg::REG_WT0) ? 11'(val) : 11'(val & 8'hFF);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned wts [6]);
        drain();
        apb_write(gsed_pkg::REG_WIDTH, w);
        apb_write(gsed_pkg::REG_HEIGHT, h);
        apb_write(gsed_pkg::REG_WT0, wts[0]);
        apb_write(gsed_pkg::REG_WT1, wts[1]);
        apb_write(gsed_pkg::REG_WT2, wts[2]);
        apb_write(gsed_pkg::REG_WT4, wts[3]);
        apb_write(gsed_pkg::REG_WT5, wts[4]);
        apb_write(gsed_pkg::REG_WT8, wts[5]);
    endtask

    task automatic send_request(bit c, bit [7:0] p);
        int r;
        r = $urandom_range(0, 99);
        if (!steady && r >= 60)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ((r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 60)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        pixel <= p;
        forever
        begin
            @(posedge clk);
            if (in_ready) break;
        end
        sb.note_request(c, p);
        sent++;
    endtask

    function automatic bit [7:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_frame();
        bit halted;
        halted = 1'b0;
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) send_request(1'b1, rand_pixel());
        send_request(1'b0, rand_pixel());
        while (sb.active())
        begin
            if (!halted && $urandom_range(0, 40) == 0)
            begin
                halted = 1'b1;
                drain();
            end
            if (!sb.complete())
                send_request($urandom_range(0, 15) == 0, rand_pixel());
            else
                send_request(1'($urandom), rand_pixel());
        end
    endtask

    initial
    begin
        int unsigned wts [6];
        int unsigned w, h;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wts = '{8, 6, 5, 3, 3, 1};
        configure(5, 5, wts);
        send_request(1'b1, 8'd0);
        for (int i = 0; i < 25; i++)
        begin
            if (i == 7) send_request(1'b1, 8'd255);
            send_request(1'b0, (i % 3 == 0) ? 8'd255 : ((i % 3 == 1) ? 8'd0 : 8'(i * 9)));
        end
        while (sb.active()) send_request(1'b0, 8'd170);

        wts = '{255, 255, 255, 255, 255, 255};
        configure(2047, 1, wts);
        run_frame();
        wts = '{1, 1, 1, 1, 1, 1};
        configure(1, 300, wts);
        run_frame();
        wts = '{0, 0, 0, 0, 0, 0};
        configure(7, 6, wts);
        run_frame();
        configure(0, 0, wts);
        run_frame();

        while (sent < 1850)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 14);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10);
            for (int j = 0; j < 6; j++)
                case ($urandom_range(0, 7))
                    0: wts[j] = 255;
                    1: wts[j] = 1;
                    2: wts[j] = 0;
                    default: wts[j] = $urandom_range(0, 255);
                endcase
            configure(w, h, wts);
            repeat ($urandom_range(1, 3)) run_frame();
        end

        drain();
        if (sb.errors == 0)
            $display("gaussian_smoothing_edge_difference_core_tb: done, clean");
        else
            $display("gaussian_smoothing_edge_difference_core_tb: done, errors");
        $finish;
    end
endmodule
